// ===== sv/ecc_pkg.sv =====
`timescale 1ns / 1ps

package ecc_pkg;

  localparam int IN_W      = 24;
  localparam int OUT_W     = 48;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FAST_PERIOD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_PERIOD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DOOR_OPEN_AT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DOOR_CLOSE_AT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DOOR_DONE_AT  = 3'd4;

  localparam logic [9:0] JOY_UP_FAST = 10'd800;
  localparam logic [9:0] JOY_UP_SLOW = 10'd530;
  localparam logic [9:0] JOY_DN_FAST = 10'd200;
  localparam logic [9:0] JOY_DN_SLOW = 10'd470;

  localparam logic [2:0] BAND_UP_FAST = 3'd0;
  localparam logic [2:0] BAND_UP_SLOW = 3'd1;
  localparam logic [2:0] BAND_DN_FAST = 3'd2;
  localparam logic [2:0] BAND_DN_SLOW = 3'd3;
  localparam logic [2:0] BAND_HOLD    = 3'd4;

  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  localparam logic [3:0]  TOP_LEVEL    = 4'd12;
  localparam logic [15:0] SINCE_MAX    = 16'hFFFF;
  localparam logic [10:0] DOOR_T_MAX   = 11'h7FF;

  typedef struct packed {
    logic       slow;
    logic       service;
    logic [2:0] band;
    logic       push;
    logic [1:0] rfloor;
    logic [1:0] rtarget;
  } item_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
  } cfg_t;

endpackage

// ===== sv/elevator_car_controller.sv =====
`timescale 1ns / 1ps

// Four-floor elevator car controller, one input transfer per 1 ms tick.
// s_axis: tick with switches, joystick and an optional passenger request.
// m_axis: car status after that tick, exactly one transfer per input transfer.
// cfg: write-only register port (move periods, door cycle thresholds),
//   written while no tick is in flight.
// Path: the input is classified combinationally and written into a two-entry
//   queue; the state update pops it and registers the result and m_tvalid.
// Throughput: one tick per cycle while m_tready stays high.
// Request queue sits in a RAM; its registered read is bypassed when the
//   entry being read was written the cycle before.
// Reset: car at ground floor, stationary, doors closed, queue empty,
//   counters zero, registers at their defaults. No clearing pass.
// Stall: while m_tready is low the result register holds; the queue keeps
//   taking up to two more ticks, then s_tready drops.
module elevator_car_controller import ecc_pkg::*; #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int COUNTER_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // slow_switch, service_switch, joystick[9:0], request_valid,
  // request_floor[1:0], request_target[1:0], zero pad
  input  logic [IN_W-1:0]      s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // car_level[3:0], travel_direction[1:0], passenger_aboard, door_open,
  // door_cycle_busy, floors_loaded[15:0], floors_empty[15:0],
  // waiting_count[4:0], request_dropped, zero pad
  output logic [OUT_W-1:0]     m_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  item_t front_item;
  item_t back_item;
  logic  back_valid;
  logic  back_ready;
  cfg_t  cfg;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  ecc_front u_front (
    .tdata (s_tdata),
    .item  (front_item)
  );

  ecc_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (s_tvalid),
    .push_ready (s_tready),
    .push_data  (front_item),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_item)
  );

  ecc_back #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (back_valid),
    .item_ready (back_ready),
    .item       (back_item),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (m_tdata)
  );

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[3:0] <= TOP_LEVEL))
    else $error("car level beyond top floor");

  a_dir_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[5:4] != 2'd3))
    else $error("bad travel direction");

  a_open_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[7]) |-> m_tdata[8])
    else $error("doors open outside a door cycle");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (back_valid && back_ready) |=> m_tvalid)
    else $error("tick executed without a result");

endmodule

// ===== sv/ecc_ram.sv =====
`timescale 1ns / 1ps

module ecc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ecc_front.sv =====
`timescale 1ns / 1ps

module ecc_front import ecc_pkg::*; (
  input  logic [IN_W-1:0] tdata,
  output item_t           item
);

  logic [9:0] joy;

  assign joy = tdata[11:2];

  always_comb begin
    item.slow    = tdata[0];
    item.service = tdata[1];
    item.rfloor  = tdata[14:13];
    item.rtarget = tdata[16:15];
    // same-floor requests are dropped here, never reported
    item.push    = tdata[12] && (tdata[14:13] != tdata[16:15]);
    if (joy > JOY_UP_FAST) begin
      item.band = BAND_UP_FAST;
    end else if (joy > JOY_UP_SLOW) begin
      item.band = BAND_UP_SLOW;
    end else if (joy < JOY_DN_FAST) begin
      item.band = BAND_DN_FAST;
    end else if (joy < JOY_DN_SLOW) begin
      item.band = BAND_DN_SLOW;
    end else begin
      item.band = BAND_HOLD;
    end
  end

endmodule

// ===== sv/ecc_fifo.sv =====
`timescale 1ns / 1ps

module ecc_fifo import ecc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_data,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_data
);

  item_t      slot [2];
  logic [1:0] count;
  logic       wp;
  logic       rp;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slot[rp];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wp    <= 1'b0;
      rp    <= 1'b0;
    end else begin
      if (do_push) begin
        wp <= ~wp;
      end
      if (do_pop) begin
        rp <= ~rp;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wp] <= push_data;
    end
  end

endmodule

// ===== sv/ecc_back.sv =====
`timescale 1ns / 1ps

module ecc_back import ecc_pkg::*; #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int COUNTER_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             item_valid,
  output logic             item_ready,
  input  item_t            item,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

  logic [9:0]  fast_period, slow_period;
  logic [10:0] door_open_at, door_close_at, door_done_at;

  logic [3:0]              level, level_next;
  logic [3:0]              target, target_next;
  logic [1:0]              direction, direction_next;
  logic [15:0]             since_move, since_move_next;
  logic                    door_busy, door_busy_next;
  logic [10:0]             door_elapsed, door_elapsed_next;
  logic                    aboard, aboard_next;
  logic [COUNTER_BITS-1:0] loaded_count, loaded_count_next;
  logic [COUNTER_BITS-1:0] empty_count, empty_count_next;
  logic [AW-1:0]           head, head_next;
  logic [AW-1:0]           tail, tail_next;
  logic [FW-1:0]           fill, fill_next;
  logic                    byp_hit;
  logic [3:0]              byp_entry;

  logic        step;
  logic [9:0]  period;
  logic        upd;
  logic        moving;
  logic        open;
  logic        dropped;
  logic        push_ok;
  logic [3:0]  new_entry;
  logic [3:0]  ram_q;
  logic [3:0]  head_entry;
  logic [3:0]  start_lvl;
  logic [3:0]  dest_lvl;

  assign item_ready = !out_valid || out_ready;
  assign step       = item_valid && item_ready;
  assign new_entry  = {item.rtarget, item.rfloor};

  ecc_ram #(.WIDTH(4), .DEPTH(QUEUE_DEPTH)) u_req_ram (
    .clk   (clk),
    .we    (push_ok),
    .waddr (tail),
    .wdata (new_entry),
    .raddr (head_next),
    .rdata (ram_q)
  );

  always_comb begin
    if (fill == '0) begin
      head_entry = new_entry;
    end else if (byp_hit) begin
      head_entry = byp_entry;
    end else begin
      head_entry = ram_q;
    end
  end

  assign start_lvl = {head_entry[1:0], 2'b00};
  assign dest_lvl  = {head_entry[3:2], 2'b00};

  always_comb begin
    level_next        = level;
    target_next       = target;
    direction_next    = direction;
    since_move_next   = since_move;
    door_busy_next    = door_busy;
    door_elapsed_next = door_elapsed;
    aboard_next       = aboard;
    loaded_count_next = loaded_count;
    empty_count_next  = empty_count;
    head_next         = head;
    tail_next         = tail;
    fill_next         = fill;
    period            = item.slow ? slow_period : fast_period;
    upd               = 1'b0;
    moving            = 1'b0;
    open              = 1'b0;
    dropped           = 1'b0;
    push_ok           = 1'b0;

    if (step) begin
      if (since_move != SINCE_MAX) begin
        since_move_next = since_move + 16'd1;
      end
      if (door_busy && door_elapsed != DOOR_T_MAX) begin
        door_elapsed_next = door_elapsed + 11'd1;
      end

      if (item.service) begin
        unique case (item.band)
          BAND_UP_FAST: begin
            target_next = TOP_LEVEL;
            period      = fast_period;
          end
          BAND_UP_SLOW: begin
            target_next = TOP_LEVEL;
            period      = slow_period;
          end
          BAND_DN_FAST: begin
            target_next = 4'd0;
            period      = fast_period;
          end
          BAND_DN_SLOW: begin
            target_next = 4'd0;
            period      = slow_period;
          end
          default: begin
            target_next    = level;
            direction_next = DIR_STOP;
          end
        endcase
      end

      upd = (since_move_next > {6'd0, period}) && !door_busy;
      if (upd) begin
        if (target_next > level) begin
          direction_next = DIR_UP;
          level_next     = level + 4'd1;
        end else if (target_next < level) begin
          direction_next = DIR_DOWN;
          level_next     = level - 4'd1;
        end else begin
          direction_next = DIR_STOP;
        end
        since_move_next = 16'd0;
      end

      moving = (direction_next != DIR_STOP);
      if (upd && moving && level_next[1:0] == 2'b00) begin
        if (aboard) begin
          if (loaded_count != CNT_MAX) begin
            loaded_count_next = loaded_count + COUNTER_BITS'(1);
          end
        end else if (empty_count != CNT_MAX) begin
          empty_count_next = empty_count + COUNTER_BITS'(1);
        end
      end

      if (item.push) begin
        if (fill >= FW'(QUEUE_DEPTH)) begin
          dropped = 1'b1;
        end else begin
          push_ok   = 1'b1;
          tail_next = (tail == AW'(QUEUE_DEPTH - 1)) ? '0 : tail + AW'(1);
          fill_next = fill + FW'(1);
        end
      end

      if (fill_next != '0 && upd && !item.service) begin
        if (level_next == start_lvl) begin
          target_next       = dest_lvl;
          aboard_next       = 1'b1;
          door_busy_next    = 1'b1;
          door_elapsed_next = 11'd0;
        end else if (!moving) begin
          target_next = start_lvl;
          aboard_next = 1'b0;
        end else if (level_next == dest_lvl && target_next == dest_lvl) begin
          aboard_next       = 1'b0;
          head_next         = (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + AW'(1);
          fill_next         = fill_next - FW'(1);
          door_busy_next    = 1'b1;
          door_elapsed_next = 11'd0;
        end
      end

      // end check wins over close, close over open
      if (door_busy_next) begin
        if (door_elapsed_next > door_done_at) begin
          door_busy_next = 1'b0;
        end else if (door_elapsed_next > door_close_at) begin
          open = 1'b0;
        end else if (door_elapsed_next > door_open_at) begin
          open = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fast_period   <= 10'd100;
      slow_period   <= 10'd300;
      door_open_at  <= 11'd400;
      door_close_at <= 11'd800;
      door_done_at  <= 11'd1200;
    end else if (cfg.we) begin
      unique case (cfg.index)
        REG_FAST_PERIOD:   fast_period   <= cfg.data[9:0];
        REG_SLOW_PERIOD:   slow_period   <= cfg.data[9:0];
        REG_DOOR_OPEN_AT:  door_open_at  <= cfg.data;
        REG_DOOR_CLOSE_AT: door_close_at <= cfg.data;
        REG_DOOR_DONE_AT:  door_done_at  <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level        <= 4'd0;
      target       <= 4'd0;
      direction    <= DIR_STOP;
      since_move   <= 16'd0;
      door_busy    <= 1'b0;
      door_elapsed <= 11'd0;
      aboard       <= 1'b0;
      loaded_count <= '0;
      empty_count  <= '0;
      head         <= '0;
      tail         <= '0;
      fill         <= '0;
      byp_hit      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      level        <= level_next;
      target       <= target_next;
      direction    <= direction_next;
      since_move   <= since_move_next;
      door_busy    <= door_busy_next;
      door_elapsed <= door_elapsed_next;
      aboard       <= aboard_next;
      loaded_count <= loaded_count_next;
      empty_count  <= empty_count_next;
      head         <= head_next;
      tail         <= tail_next;
      fill         <= fill_next;
      // RAM read is registered; forward a write that lands on the next head
      byp_hit      <= push_ok && (tail == head_next);
      if (step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    byp_entry <= new_entry;
    if (step) begin
      out_data <= {1'b0, dropped, 5'(fill_next), 16'(empty_count_next),
                   16'(loaded_count_next), door_busy_next, open, aboard_next,
                   direction_next, level_next};
    end
  end

endmodule
